// ----- hdl/cbmm_pkg.sv -----
package cbmm_pkg;

    typedef enum logic [1:0] {
        CMD_CPU_RD = 2'd0,
        CMD_CPU_WR = 2'd1,
        CMD_PIC_RD = 2'd2,
        CMD_PIC_WR = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        TGT_RAM    = 3'd0,
        TGT_PREG   = 3'd1,
        TGT_IO     = 3'd2,
        TGT_CART   = 3'd3,
        TGT_NT     = 3'd4,
        TGT_PAL    = 3'd5,
        TGT_UNUSED = 3'd6
    } t_target;

    // which store drives the read data of a completed transaction
    typedef enum logic [1:0] {
        RSEL_NONE = 2'd0,
        RSEL_RAM  = 2'd1,
        RSEL_NT   = 2'd2,
        RSEL_PAL  = 2'd3
    } t_rsel;

    localparam int TABLE_DEPTH   = 1024;
    localparam int PALETTE_DEPTH = 32;
    localparam int NT_AW         = $clog2(2 * TABLE_DEPTH);
    localparam int TBL_AW        = $clog2(TABLE_DEPTH);
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    localparam logic [15:0] MIRROR_TOP   = 16'h1FFF;
    localparam logic [15:0] PREG_TOP     = 16'h3FFF;
    localparam logic [15:0] PREG_MASK    = 16'h2007;
    localparam logic [15:0] IO_TOP       = 16'h401F;
    localparam logic [15:0] NT_TOP       = 16'h2FFF;
    localparam logic [15:0] NT_UPPER     = 16'h2800;
    localparam logic [15:0] UNUSED_TOP   = 16'h3EFF;
    localparam logic [15:0] TBL_MASK     = 16'h03FF;
    localparam logic [15:0] PAL_MASK     = 16'h001F;

endpackage

// ----- hdl/console_bus_memory_map.sv -----
// each taken transaction shows its result, with o_valid high, from registers loaded
// at the clock edge that takes it
// throughput: one transaction per clock; o_busy stays low, since each read of the three
// block RAMs is registered, and a read right after a write sees the new byte
// reset: synchronous active-low i_rst_n clears the result strobe; RAM contents are
// left as they are, and the receiver cannot stall
module console_bus_memory_map #(
    parameter int RAM_DEPTH = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_bus_address,
    input  logic [7:0]  i_write_byte,
    output logic        o_valid,
    output logic [7:0]  o_read_byte,
    output logic [2:0]  o_target,
    output logic [15:0] o_forward_address,
    output logic        o_invalid_access
);

    localparam int RAM_AW = $clog2(RAM_DEPTH);

    logic                    accept;
    logic                    wr;
    logic [12:0]             ram_idx;
    logic [12:0]             ram_s1;
    logic [12:0]             ram_s2;
    logic [12:0]             ram_s3;
    logic                    ram_en;
    logic                    nt_en;
    logic                    pal_en;
    logic [cbmm_pkg::NT_AW-1:0]  nt_addr;
    logic [cbmm_pkg::PAL_AW-1:0] pal_addr;
    logic [15:0]             tbl_bits;
    logic [15:0]             pal_bits;
    logic [7:0]              ram_q;
    logic [7:0]              nt_q;
    logic [7:0]              pal_q;

    cbmm_pkg::t_target n_target;
    cbmm_pkg::t_rsel   n_rsel;
    logic [15:0]       n_fwd;
    logic              n_bad;

    logic              r_valid;
    cbmm_pkg::t_target r_target;
    cbmm_pkg::t_rsel   r_rsel;
    logic [15:0]       r_fwd;
    logic              r_bad;

    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;
    assign wr     = i_cmd[0];

    // mirror the 8 KB window down onto the work ram; depth must be at least 2 KB, which the
    // block does not check, so that three conditional subtracts cover any depth in range
    always_comb begin
        ram_s1 = i_bus_address[12:0];
        if (ram_s1 >= 13'(RAM_DEPTH)) ram_s2 = ram_s1 - 13'(RAM_DEPTH);
        else                          ram_s2 = ram_s1;
        if (ram_s2 >= 13'(RAM_DEPTH)) ram_s3 = ram_s2 - 13'(RAM_DEPTH);
        else                          ram_s3 = ram_s2;
        if (ram_s3 >= 13'(RAM_DEPTH)) ram_idx = ram_s3 - 13'(RAM_DEPTH);
        else                          ram_idx = ram_s3;
    end

    // horizontal mirroring: upper half of the name table window uses table 1
    assign tbl_bits = i_bus_address & cbmm_pkg::TBL_MASK;
    assign pal_bits = i_bus_address & cbmm_pkg::PAL_MASK;
    assign nt_addr  = {i_bus_address >= cbmm_pkg::NT_UPPER, tbl_bits[cbmm_pkg::TBL_AW-1:0]};
    assign pal_addr = pal_bits[cbmm_pkg::PAL_AW-1:0];

    always_comb begin
        n_target = cbmm_pkg::TGT_UNUSED;
        n_rsel   = cbmm_pkg::RSEL_NONE;
        n_fwd    = 16'h0000;
        n_bad    = 1'b0;
        ram_en   = 1'b0;
        nt_en    = 1'b0;
        pal_en   = 1'b0;
        unique case (cbmm_pkg::t_cmd'(i_cmd))
            cbmm_pkg::CMD_CPU_RD, cbmm_pkg::CMD_CPU_WR: begin
                if (i_bus_address <= cbmm_pkg::MIRROR_TOP) begin
                    n_target = cbmm_pkg::TGT_RAM;
                    ram_en   = 1'b1;
                    if (!wr) n_rsel = cbmm_pkg::RSEL_RAM;
                end else if (i_bus_address <= cbmm_pkg::PREG_TOP) begin
                    n_target = cbmm_pkg::TGT_PREG;
                    n_fwd    = i_bus_address & cbmm_pkg::PREG_MASK;
                end else if (i_bus_address <= cbmm_pkg::IO_TOP) begin
                    n_target = cbmm_pkg::TGT_IO;
                end else begin
                    n_target = cbmm_pkg::TGT_CART;
                    if (wr) n_bad = 1'b1;
                    else    n_fwd = i_bus_address;
                end
            end
            cbmm_pkg::CMD_PIC_RD, cbmm_pkg::CMD_PIC_WR: begin
                if (i_bus_address <= cbmm_pkg::MIRROR_TOP) begin
                    n_target = cbmm_pkg::TGT_CART;
                    if (wr) n_bad = 1'b1;
                    else    n_fwd = i_bus_address;
                end else if (i_bus_address <= cbmm_pkg::NT_TOP) begin
                    n_target = cbmm_pkg::TGT_NT;
                    nt_en    = 1'b1;
                    if (!wr) n_rsel = cbmm_pkg::RSEL_NT;
                end else if (i_bus_address <= cbmm_pkg::UNUSED_TOP) begin
                    n_target = cbmm_pkg::TGT_UNUSED;
                end else if (i_bus_address <= cbmm_pkg::PREG_TOP) begin
                    n_target = cbmm_pkg::TGT_PAL;
                    pal_en   = 1'b1;
                    if (!wr) n_rsel = cbmm_pkg::RSEL_PAL;
                end else begin
                    n_target = cbmm_pkg::TGT_UNUSED;
                    n_bad    = 1'b1;
                end
            end
            default: begin
                n_target = cbmm_pkg::TGT_UNUSED;
            end
        endcase
    end

    cbmm_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_work_ram (
        .i_clk   (i_clk),
        .i_en    (accept && ram_en),
        .i_we    (wr),
        .i_addr  (ram_idx[RAM_AW-1:0]),
        .i_wdata (i_write_byte),
        .o_rdata (ram_q)
    );

    cbmm_ram #(.WIDTH(8), .DEPTH(2 * cbmm_pkg::TABLE_DEPTH)) u_name_table (
        .i_clk   (i_clk),
        .i_en    (accept && nt_en),
        .i_we    (wr),
        .i_addr  (nt_addr),
        .i_wdata (i_write_byte),
        .o_rdata (nt_q)
    );

    cbmm_ram #(.WIDTH(8), .DEPTH(cbmm_pkg::PALETTE_DEPTH)) u_palette (
        .i_clk   (i_clk),
        .i_en    (accept && pal_en),
        .i_we    (wr),
        .i_addr  (pal_addr),
        .i_wdata (i_write_byte),
        .o_rdata (pal_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_target <= n_target;
            r_rsel   <= n_rsel;
            r_fwd    <= n_fwd;
            r_bad    <= n_bad;
        end
    end

    always_comb begin
        unique case (r_rsel)
            cbmm_pkg::RSEL_RAM: o_read_byte = ram_q;
            cbmm_pkg::RSEL_NT:  o_read_byte = nt_q;
            cbmm_pkg::RSEL_PAL: o_read_byte = pal_q;
            default:            o_read_byte = 8'h00;
        endcase
    end

    assign o_valid           = r_valid;
    assign o_target          = r_target;
    assign o_forward_address = r_fwd;
    assign o_invalid_access  = r_bad;

endmodule

// ----- hdl/cbmm_ram.sv -----
module cbmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- tb/sv/console_bus_memory_map_tb.sv -----
module console_bus_memory_map_tb;

    localparam int RAM_DEPTH   = 2048;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 560;

    typedef struct packed {
        logic [7:0]        rd;
        cbmm_pkg::t_target tgt;
        logic [15:0]       fwd;
        logic              bad;
    } t_bus_result;

    typedef struct packed {
        cbmm_pkg::t_cmd cmd;
        logic [15:0]    addr;
        logic [7:0]     data;
        logic           known;
        t_bus_result    want;
    } t_access_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [1:0]  i_cmd;
    logic [15:0] i_bus_address;
    logic [7:0]  i_write_byte;
    logic        o_valid;
    logic [7:0]  o_read_byte;
    logic [2:0]  o_target;
    logic [15:0] o_forward_address;
    logic        o_invalid_access;

    // shadow copies of the three stores and which entries hold known data
    logic [7:0] ram_shadow [RAM_DEPTH];
    logic [7:0] nt_shadow  [2 * cbmm_pkg::TABLE_DEPTH];
    logic [7:0] pal_shadow [cbmm_pkg::PALETTE_DEPTH];
    bit         ram_known  [RAM_DEPTH];
    bit         nt_known   [2 * cbmm_pkg::TABLE_DEPTH];
    bit         pal_known  [cbmm_pkg::PALETTE_DEPTH];

    t_bus_result pending_results [$];
    t_bus_result oldest;
    int          mismatch_count;
    int          cycle_count;
    int          idle_pct;

    // directed accesses; known rows carry the result typed in
    t_access_row directed_rows [0:24] = '{
        '{cbmm_pkg::CMD_CPU_WR, 16'h0000, 8'hFF, 1'b1,
          '{8'h00, cbmm_pkg::TGT_RAM,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'h1800, 8'h00, 1'b1,
          '{8'hFF, cbmm_pkg::TGT_RAM,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_WR, 16'h07FF, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_RAM,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'h1FFF, 8'hFF, 1'b1,
          '{8'h00, cbmm_pkg::TGT_RAM,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'h2000, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_PREG,   16'h2000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_WR, 16'h3FFF, 8'hA5, 1'b1,
          '{8'h00, cbmm_pkg::TGT_PREG,   16'h2007, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'h4000, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_IO,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_WR, 16'h401F, 8'h3C, 1'b1,
          '{8'h00, cbmm_pkg::TGT_IO,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'h4020, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'h4020, 1'b0}},
        '{cbmm_pkg::CMD_CPU_RD, 16'hFFFF, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'hFFFF, 1'b0}},
        '{cbmm_pkg::CMD_CPU_WR, 16'hFFFF, 8'h5A, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'h0000, 1'b1}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h0000, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h1FFF, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'h1FFF, 1'b0}},
        '{cbmm_pkg::CMD_PIC_WR, 16'h1234, 8'h99, 1'b1,
          '{8'h00, cbmm_pkg::TGT_CART,   16'h0000, 1'b1}},
        '{cbmm_pkg::CMD_PIC_WR, 16'h2000, 8'h11, 1'b1,
          '{8'h00, cbmm_pkg::TGT_NT,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h2400, 8'h00, 1'b1,
          '{8'h11, cbmm_pkg::TGT_NT,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_WR, 16'h2800, 8'h22, 1'b1,
          '{8'h00, cbmm_pkg::TGT_NT,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h2C00, 8'h00, 1'b1,
          '{8'h22, cbmm_pkg::TGT_NT,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h2000, 8'h00, 1'b0,
          '{8'h00, cbmm_pkg::TGT_NT,     16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h3000, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_UNUSED, 16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_WR, 16'h3EFF, 8'h77, 1'b1,
          '{8'h00, cbmm_pkg::TGT_UNUSED, 16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_WR, 16'h3F00, 8'h3C, 1'b1,
          '{8'h00, cbmm_pkg::TGT_PAL,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h3FE0, 8'h00, 1'b1,
          '{8'h3C, cbmm_pkg::TGT_PAL,    16'h0000, 1'b0}},
        '{cbmm_pkg::CMD_PIC_RD, 16'h4000, 8'h00, 1'b1,
          '{8'h00, cbmm_pkg::TGT_UNUSED, 16'h0000, 1'b1}},
        '{cbmm_pkg::CMD_PIC_WR, 16'hFFFF, 8'hFF, 1'b1,
          '{8'h00, cbmm_pkg::TGT_UNUSED, 16'h0000, 1'b1}}
    };

    console_bus_memory_map #(
        .RAM_DEPTH(RAM_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_cmd            (i_cmd),
        .i_bus_address    (i_bus_address),
        .i_write_byte     (i_write_byte),
        .o_valid          (o_valid),
        .o_read_byte      (o_read_byte),
        .o_target         (o_target),
        .o_forward_address(o_forward_address),
        .o_invalid_access (o_invalid_access)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // horizontal mirroring: quadrants 2 and 3 land in the second table
    function automatic int nt_index(logic [15:0] a);
        int base;
        base = (a >= cbmm_pkg::NT_UPPER) ? cbmm_pkg::TABLE_DEPTH : 0;
        return base + int'(a & cbmm_pkg::TBL_MASK);
    endfunction

    function automatic t_bus_result decode_access(cbmm_pkg::t_cmd c, logic [15:0] a,
                                                  logic [7:0] d);
        t_bus_result r;
        logic        wr;
        int          idx;
        r  = '{8'h00, cbmm_pkg::TGT_UNUSED, 16'h0000, 1'b0};
        wr = (c == cbmm_pkg::CMD_CPU_WR) || (c == cbmm_pkg::CMD_PIC_WR);
        if (c == cbmm_pkg::CMD_CPU_RD || c == cbmm_pkg::CMD_CPU_WR) begin
            if (a <= cbmm_pkg::MIRROR_TOP) begin
                idx   = int'(a) % RAM_DEPTH;
                r.tgt = cbmm_pkg::TGT_RAM;
                if (wr) begin
                    ram_shadow[idx] = d;
                    ram_known[idx]  = 1'b1;
                end else begin
                    r.rd = ram_shadow[idx];
                end
            end else if (a <= cbmm_pkg::PREG_TOP) begin
                r.tgt = cbmm_pkg::TGT_PREG;
                r.fwd = a & cbmm_pkg::PREG_MASK;
            end else if (a <= cbmm_pkg::IO_TOP) begin
                r.tgt = cbmm_pkg::TGT_IO;
            end else begin
                r.tgt = cbmm_pkg::TGT_CART;
                if (wr) r.bad = 1'b1;
                else r.fwd = a;
            end
        end else begin
            if (a <= cbmm_pkg::MIRROR_TOP) begin
                r.tgt = cbmm_pkg::TGT_CART;
                if (wr) r.bad = 1'b1;
                else r.fwd = a;
            end else if (a <= cbmm_pkg::NT_TOP) begin
                idx   = nt_index(a);
                r.tgt = cbmm_pkg::TGT_NT;
                if (wr) begin
                    nt_shadow[idx] = d;
                    nt_known[idx]  = 1'b1;
                end else begin
                    r.rd = nt_shadow[idx];
                end
            end else if (a <= cbmm_pkg::UNUSED_TOP) begin
                r.tgt = cbmm_pkg::TGT_UNUSED;
            end else if (a <= cbmm_pkg::PREG_TOP) begin
                idx   = int'(a & cbmm_pkg::PAL_MASK);
                r.tgt = cbmm_pkg::TGT_PAL;
                if (wr) begin
                    pal_shadow[idx] = d;
                    pal_known[idx]  = 1'b1;
                end else begin
                    r.rd = pal_shadow[idx];
                end
            end else begin
                r.tgt = cbmm_pkg::TGT_UNUSED;
                r.bad = 1'b1;
            end
        end
        return r;
    endfunction

    // a read of a store entry that was never written is kept out of the stimulus
    function automatic bit reads_blank_entry(cbmm_pkg::t_cmd c, logic [15:0] a);
        if (c == cbmm_pkg::CMD_CPU_RD && a <= cbmm_pkg::MIRROR_TOP)
            return !ram_known[int'(a) % RAM_DEPTH];
        if (c == cbmm_pkg::CMD_PIC_RD && a > cbmm_pkg::MIRROR_TOP && a <= cbmm_pkg::NT_TOP)
            return !nt_known[nt_index(a)];
        if (c == cbmm_pkg::CMD_PIC_RD && a > cbmm_pkg::UNUSED_TOP && a <= cbmm_pkg::PREG_TOP)
            return !pal_known[int'(a & cbmm_pkg::PAL_MASK)];
        return 1'b0;
    endfunction

    function automatic logic [15:0] pick_address(cbmm_pkg::t_cmd c);
        logic [15:0] a;
        case ($urandom_range(7))
            0, 1, 2: begin
                // store accesses, often folded onto a few low entries so reads hit data
                if (c == cbmm_pkg::CMD_CPU_RD || c == cbmm_pkg::CMD_CPU_WR) begin
                    a = 16'($urandom_range(0, 16'h1FFF));
                    if ($urandom_range(1)) a[10:4] = '0;
                end else if ($urandom_range(1)) begin
                    a = 16'($urandom_range(16'h2000, 16'h2FFF));
                    if ($urandom_range(1)) a[9:4] = '0;
                end else begin
                    a = 16'($urandom_range(16'h3F00, 16'h3FFF));
                end
            end
            3:       a = 16'($urandom_range(16'h2000, 16'h3FFF));
            4:       a = 16'($urandom_range(16'h3000, 16'h401F));
            5:       a = 16'($urandom_range(16'h4020, 16'hFFFF));
            6:       a = 16'($urandom_range(16'h0000, 16'h1FFF));
            default: a = 16'($urandom);
        endcase
        return a;
    endfunction

    task automatic issue_access(input cbmm_pkg::t_cmd c, input logic [15:0] a,
                                input logic [7:0] d, input bit known,
                                input t_bus_result typed);
        t_bus_result predicted;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            i_start       <= 1'b0;
            i_cmd         <= 2'($urandom_range(3));
            i_bus_address <= 16'($urandom);
            i_write_byte  <= 8'($urandom);
        end
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_cmd         <= c;
        i_bus_address <= a;
        i_write_byte  <= d;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        predicted = decode_access(c, a, d);
        pending_results.push_back(known ? typed : predicted);
    endtask

    task automatic random_accesses(input int count);
        cbmm_pkg::t_cmd c;
        logic [15:0]    a;
        for (int n = 0; n < count; n++) begin
            c = cbmm_pkg::t_cmd'($urandom_range(3));
            a = pick_address(c);
            if (reads_blank_entry(c, a)) c = cbmm_pkg::t_cmd'(c | 2'b01);
            issue_access(c, a, 8'($urandom), 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid !== 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: rd %h tgt %0d fwd %h bad %b",
                             o_read_byte, o_target, o_forward_address, o_invalid_access);
            end else begin
                oldest = pending_results.pop_front();
                if (o_read_byte !== oldest.rd || o_target !== oldest.tgt ||
                    o_forward_address !== oldest.fwd || o_invalid_access !== oldest.bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("mismatch: expected rd %h tgt %0d fwd %h bad %b, ",
                               oldest.rd, oldest.tgt, oldest.fwd, oldest.bad);
                        $display("got rd %h tgt %0d fwd %h bad %b",
                                 o_read_byte, o_target, o_forward_address, o_invalid_access);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_cmd          = cbmm_pkg::CMD_CPU_RD;
        i_bus_address  = '0;
        i_write_byte   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_pct       = 16;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            issue_access(directed_rows[k].cmd, directed_rows[k].addr, directed_rows[k].data,
                         directed_rows[k].known, directed_rows[k].want);
        random_accesses(RANDOM_PER_PHASE);
        idle_pct = 49;
        random_accesses(RANDOM_PER_PHASE);
        idle_pct = 0;
        random_accesses(RANDOM_PER_PHASE);

        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/cbmm_pkg.sv
hdl/cbmm_ram.sv
hdl/console_bus_memory_map.sv
tb/sv/console_bus_memory_map_tb.sv
